// ----- rtl/jcn_pkg.sv -----
package jcn_pkg;

	localparam int SAMPLE_W      = 8;
	localparam int PERCENT_SCALE = 100;
	localparam int PERCENT_MAX   = 100;
	localparam int DZ_W          = 7;
	localparam int MARGIN_W      = 8;
	localparam int DIR_W         = 3;

	localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
	localparam int DIV_W      = $clog2(SAMPLE_MAX * PERCENT_SCALE + 1);
	localparam int CNT_W      = $clog2(DIV_W);

	localparam logic [DZ_W-1:0]     DEAD_ZONE_RST = DZ_W'(10);
	localparam logic [MARGIN_W-1:0] MARGIN_RST    = MARGIN_W'(10);

	localparam logic [1:0] ACT_CAPTURE   = 2'd0;
	localparam logic [1:0] ACT_CALIBRATE = 2'd1;
	localparam logic [1:0] ACT_READ      = 2'd2;

	localparam logic [DIR_W-1:0] DIR_NEUTRAL = 3'd0;
	localparam logic [DIR_W-1:0] DIR_RIGHT   = 3'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT    = 3'd2;
	localparam logic [DIR_W-1:0] DIR_UP      = 3'd3;
	localparam logic [DIR_W-1:0] DIR_DOWN    = 3'd4;

	localparam logic REG_DEAD_ZONE = 1'b0;
	localparam logic REG_MARGIN    = 1'b1;

	typedef struct packed {
		logic [1:0]          action;
		logic [SAMPLE_W-1:0] x_sample;
		logic [SAMPLE_W-1:0] y_sample;
	} jcn_in_t;

	typedef struct packed {
		logic signed [7:0]  x_percent;
		logic signed [7:0]  y_percent;
		logic [DIR_W-1:0]   direction;
	} jcn_out_t;

endpackage

// ----- rtl/joystick_calibrate_normalize.sv -----
// Channel   | Signals                              | Direction
// sample    | sample_valid, sample_ready, sample   | in
// result    | result_valid, result_ready, result   | out
// apb       | psel, penable, pwrite, paddr, ...    | in/out
//
// Each item is accepted in ST_IDLE, then runs through ST_DIV, the bit-serial restoring divider
// (one quotient bit per axis per cycle), and ST_FIN, which saturates, applies the dead zone
// and loads the result register.
// The next item is taken as soon as the divider is free, even while a result waits.
// arst_n clears calibration to neutral 0, maximum 0, minimum 255, registers to 10.
// A stalled result holds the divider in its final cycle until the result register frees.
module joystick_calibrate_normalize import jcn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  jcn_in_t     sample,
	output logic        result_valid,
	input  logic        result_ready,
	output jcn_out_t    result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]          state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DZ_W-1:0]     dead_zone_q;
	logic [MARGIN_W-1:0] margin_q;

	logic [SAMPLE_W-1:0] neutral_q [2];
	logic [SAMPLE_W-1:0] max_q     [2];
	logic [SAMPLE_W-1:0] min_q     [2];

	logic [DIV_W-1:0]    num_q  [2];
	logic [DIV_W-1:0]    quo_q  [2];
	logic [SAMPLE_W-1:0] rem_q  [2];
	logic [SAMPLE_W-1:0] div_q  [2];
	logic                neg_q  [2];
	logic                zero_q [2];
	logic [DIR_W-1:0]    dir_q;

	logic                result_valid_q;
	jcn_out_t            result_q;

	logic                take;
	logic                reg_wr;
	logic                out_free;
	logic [SAMPLE_W-1:0] smp        [2];
	logic [SAMPLE_W-1:0] absd       [2];
	logic                dneg       [2];
	logic signed [SAMPLE_W:0] span  [2];
	logic [SAMPLE_W-1:0] abs_span   [2];
	logic [DIV_W-1:0]    dividend   [2];
	logic [SAMPLE_W:0]   trial      [2];
	logic                qbit       [2];
	logic [SAMPLE_W-1:0] rem_next   [2];
	logic [DIV_W-1:0]    quo_fin    [2];
	logic [DZ_W-1:0]     mag        [2];
	logic [7:0]          pct        [2];
	logic [DIR_W-1:0]    dir_next;
	logic [SAMPLE_W:0]   x9, y9, xn9, yn9, m9;

	assign sample_ready = (state_q == ST_IDLE);
	assign take         = sample_valid && sample_ready;
	assign out_free     = !result_valid_q || result_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign pready       = 1'b1;
	assign reg_wr       = psel && penable && pwrite;

	assign smp[0] = sample.x_sample;
	assign smp[1] = sample.y_sample;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			dneg[i] = smp[i] < neutral_q[i];
			absd[i] = dneg[i] ? neutral_q[i] - smp[i] : smp[i] - neutral_q[i];
			if (dneg[i]) begin
				span[i] = $signed({1'b0, neutral_q[i]}) - $signed({1'b0, min_q[i]});
			end else begin
				span[i] = $signed({1'b0, max_q[i]}) - $signed({1'b0, neutral_q[i]});
			end
			abs_span[i] = span[i][SAMPLE_W] ? SAMPLE_W'(-span[i]) : span[i][SAMPLE_W-1:0];
			dividend[i] = DIV_W'(absd[i]) * DIV_W'(PERCENT_SCALE);

			trial[i]    = {rem_q[i], num_q[i][DIV_W-1]};
			qbit[i]     = trial[i] >= {1'b0, div_q[i]};
			rem_next[i] = qbit[i] ? SAMPLE_W'(trial[i] - {1'b0, div_q[i]})
				: trial[i][SAMPLE_W-1:0];

			quo_fin[i] = quo_q[i];
			mag[i]     = (quo_fin[i] > DIV_W'(PERCENT_MAX)) ? DZ_W'(PERCENT_MAX)
				: quo_fin[i][DZ_W-1:0];
			if (zero_q[i] || mag[i] < dead_zone_q) begin
				mag[i] = '0;
			end
			pct[i] = neg_q[i] ? 8'(-{1'b0, mag[i]}) : {1'b0, mag[i]};
		end
	end

	always_comb begin
		x9  = {1'b0, sample.x_sample};
		y9  = {1'b0, sample.y_sample};
		xn9 = {1'b0, neutral_q[0]};
		yn9 = {1'b0, neutral_q[1]};
		m9  = {1'b0, margin_q};
		if (x9 > xn9 + m9) begin
			dir_next = DIR_RIGHT;
		end else if (x9 + m9 < xn9) begin
			dir_next = DIR_LEFT;
		end else if (y9 > yn9 + m9) begin
			dir_next = DIR_UP;
		end else if (y9 + m9 < yn9) begin
			dir_next = DIR_DOWN;
		end else begin
			dir_next = DIR_NEUTRAL;
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DEAD_ZONE: prdata = 32'(dead_zone_q);
			REG_MARGIN:    prdata = 32'(margin_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= DEAD_ZONE_RST;
			margin_q    <= MARGIN_RST;
		end else if (reg_wr) begin
			unique case (paddr[2])
				REG_DEAD_ZONE: dead_zone_q <= pwdata[DZ_W-1:0];
				REG_MARGIN:    margin_q    <= pwdata[MARGIN_W-1:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				neutral_q[i] <= '0;
				max_q[i]     <= '0;
				min_q[i]     <= '1;
			end
		end else if (take) begin
			case (sample.action)
				ACT_CAPTURE: begin
					for (int i = 0; i < 2; i++) begin
						neutral_q[i] <= smp[i];
					end
				end
				ACT_CALIBRATE: begin
					for (int i = 0; i < 2; i++) begin
						if (smp[i] > max_q[i]) max_q[i] <= smp[i];
						if (smp[i] < min_q[i]) min_q[i] <= smp[i];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(DIV_W - 1)) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dir_q <= dir_next;
			for (int i = 0; i < 2; i++) begin
				num_q[i]  <= dividend[i];
				quo_q[i]  <= '0;
				rem_q[i]  <= '0;
				div_q[i]  <= abs_span[i];
				neg_q[i]  <= dneg[i] ^ span[i][SAMPLE_W];
				zero_q[i] <= (span[i] == '0);
			end
		end else if (state_q == ST_DIV) begin
			for (int i = 0; i < 2; i++) begin
				num_q[i] <= {num_q[i][DIV_W-2:0], 1'b0};
				quo_q[i] <= {quo_q[i][DIV_W-2:0], qbit[i]};
				rem_q[i] <= rem_next[i];
			end
		end
		if (state_q == ST_FIN && out_free) begin
			result_q.x_percent <= pct[0];
			result_q.y_percent <= pct[1];
			result_q.direction <= dir_q;
		end
	end

	a_take_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q == ST_DIV && cnt_q == '0))
		else $error("divider did not start on transfer");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == ST_FIN)
		else $error("result raised outside final step");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !zero_q[0]) |-> rem_q[0] < div_q[0])
		else $error("x remainder not below divisor");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($signed(result.x_percent) <= 8'sd100 &&
			$signed(result.x_percent) >= -8'sd100 &&
			$signed(result.y_percent) <= 8'sd100 &&
			$signed(result.y_percent) >= -8'sd100))
		else $error("percent out of range");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !sample_ready)
		else $error("transfer taken while dividing");

endmodule

// ----- dv/joystick_calibrate_normalize_tb.sv -----
`timescale 1ns / 1ps

module joystick_calibrate_normalize_tb;
	import jcn_pkg::*;

	localparam int QUIET_LIMIT     = 5000;
	localparam int TAIL_CYCLES     = 3 * (DIV_W + 2);
	localparam int HOLD_OFF_CYCLES = 300;

	// action code 3 is not named in the package; the block treats it as read only
	localparam logic [1:0] ACT_SPARE = 2'd3;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        sample_valid = 1'b0;
	logic        sample_ready;
	jcn_in_t     sample       = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	jcn_out_t    result;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [2:0]  paddr        = '0;
	logic [31:0] pwdata       = '0;
	logic [31:0] prdata;
	logic        pready;

	joystick_calibrate_normalize DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// calibration and register shadow
	logic [7:0]      cal_x_neutral, cal_y_neutral;
	logic [7:0]      cal_x_max, cal_x_min, cal_y_max, cal_y_min;
	logic [DZ_W-1:0] cfg_dead_zone;
	logic [7:0]      cfg_margin;

	jcn_out_t expected_results[$];
	int       error_count = 0;
	bit       idle_on     = 1'b1;
	int       hold_left   = 0;
	int       ready_burst = 0;
	int       quiet_cycles = 0;

	task automatic report_failure(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic logic signed [7:0] axis_percent(int s, int neu, int mx, int mn);
		int d, span, p;
		d = s - neu;
		span = (d >= 0) ? mx - neu : neu - mn;
		if (span == 0)
			return 8'sd0;
		p = (d * PERCENT_SCALE) / span;
		if (p > PERCENT_MAX)
			p = PERCENT_MAX;
		if (p < -PERCENT_MAX)
			p = -PERCENT_MAX;
		if ((p < 0 ? -p : p) < int'(cfg_dead_zone))
			p = 0;
		return 8'(p);
	endfunction

	// result from the calibration held before the item, then the item's own update
	function automatic jcn_out_t predict_reading(jcn_in_t item);
		jcn_out_t r;
		int xs, ys, xn, yn, m;
		xs = item.x_sample;
		ys = item.y_sample;
		xn = cal_x_neutral;
		yn = cal_y_neutral;
		m  = cfg_margin;
		r.x_percent = axis_percent(xs, xn, cal_x_max, cal_x_min);
		r.y_percent = axis_percent(ys, yn, cal_y_max, cal_y_min);
		if (xs > xn + m)
			r.direction = DIR_RIGHT;
		else if (xs < xn - m)
			r.direction = DIR_LEFT;
		else if (ys > yn + m)
			r.direction = DIR_UP;
		else if (ys < yn - m)
			r.direction = DIR_DOWN;
		else
			r.direction = DIR_NEUTRAL;
		case (item.action)
			ACT_CAPTURE: begin
				cal_x_neutral = item.x_sample;
				cal_y_neutral = item.y_sample;
			end
			ACT_CALIBRATE: begin
				if (item.x_sample > cal_x_max) cal_x_max = item.x_sample;
				if (item.x_sample < cal_x_min) cal_x_min = item.x_sample;
				if (item.y_sample > cal_y_max) cal_y_max = item.y_sample;
				if (item.y_sample < cal_y_min) cal_y_min = item.y_sample;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] pick_sample(logic [7:0] center);
		int v;
		case ($urandom_range(0, 6))
			0: return 8'h00;
			1: return 8'hFF;
			2, 3: begin
				v = $urandom_range(0, 40);
				v = v - 20 + int'(center);
				if (v < 0) v = 0;
				if (v > 255) v = 255;
				return 8'(v);
			end
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic jcn_in_t make_item(logic [1:0] act);
		jcn_in_t item;
		item.action   = act;
		item.x_sample = pick_sample(cal_x_neutral);
		item.y_sample = pick_sample(cal_y_neutral);
		return item;
	endfunction

	function automatic jcn_in_t pack_item(logic [1:0] act, int x, int y);
		jcn_in_t item;
		item.action   = act;
		item.x_sample = 8'(x);
		item.y_sample = 8'(y);
		return item;
	endfunction

	// called on a rising edge, returns on the edge of the transfer
	task automatic send_sample(input jcn_in_t item);
		bit taken;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= item;
		do begin
			@(negedge clk);
			taken = sample_ready;
			@(posedge clk);
		end while (!taken);
		expected_results.push_back(predict_reading(item));
	endtask

	task automatic drain_results();
		sample_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// write, then read back; only while the block is idle
	task automatic write_register(input logic reg_idx, input int unsigned value);
		logic [31:0] mask, readback;
		mask = (reg_idx == REG_DEAD_ZONE) ? 32'h7F : 32'hFF;
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= ($urandom() & ~mask) | (value & mask);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (reg_idx == REG_DEAD_ZONE)
			cfg_dead_zone = DZ_W'(value);
		else
			cfg_margin = 8'(value);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		readback = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if ((readback & mask) !== (value & mask))
			report_failure($sformatf("register %0d read %h, wrote %h", reg_idx,
				readback & mask, value & mask));
	endtask

	task automatic set_registers(input int unsigned dz, input int unsigned margin);
		drain_results();
		write_register(REG_DEAD_ZONE, dz);
		write_register(REG_MARGIN, margin);
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else if (ready_burst > 0) begin
			ready_burst--;
			result_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			ready_burst = $urandom_range(0, 2);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(negedge clk) begin
		jcn_out_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				report_failure($sformatf("result %h with none expected", result));
			end else begin
				want = expected_results.pop_front();
				if (result.x_percent !== want.x_percent)
					report_failure($sformatf("x_percent %0d, expected %0d",
						result.x_percent, want.x_percent));
				if (result.y_percent !== want.y_percent)
					report_failure($sformatf("y_percent %0d, expected %0d",
						result.y_percent, want.y_percent));
				if (result.direction !== want.direction)
					report_failure($sformatf("direction %0d, expected %0d",
						result.direction, want.direction));
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((sample_valid && sample_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// reset calibration state, margin boundaries, dead zone edge, zero and inverted spans
	task automatic test_directed();
		send_sample(pack_item(ACT_READ, 0, 0));
		send_sample(pack_item(ACT_READ, 255, 255));
		send_sample(pack_item(ACT_SPARE, 0, 255));
		send_sample(pack_item(ACT_CAPTURE, 128, 128));
		send_sample(pack_item(ACT_READ, 200, 60));
		send_sample(pack_item(ACT_READ, 60, 128));
		send_sample(pack_item(ACT_READ, 128, 200));
		send_sample(pack_item(ACT_READ, 128, 40));
		send_sample(pack_item(ACT_READ, 138, 128));
		send_sample(pack_item(ACT_READ, 139, 117));
		send_sample(pack_item(ACT_READ, 128, 117));
		send_sample(pack_item(ACT_READ, 118, 138));
		send_sample(pack_item(ACT_CALIBRATE, 255, 255));
		send_sample(pack_item(ACT_CALIBRATE, 0, 0));
		send_sample(pack_item(ACT_READ, 255, 0));
		send_sample(pack_item(ACT_READ, 140, 116));
		send_sample(pack_item(ACT_READ, 141, 115));
		send_sample(pack_item(ACT_CAPTURE, 255, 0));
		send_sample(pack_item(ACT_READ, 255, 0));
		send_sample(pack_item(ACT_READ, 0, 255));
		send_sample(pack_item(ACT_CALIBRATE, 100, 100));
		send_sample(pack_item(ACT_SPARE, 37, 201));
		send_sample(pack_item(ACT_CAPTURE, 0, 255));
		send_sample(pack_item(ACT_READ, 255, 0));
	endtask

	task automatic test_register_extremes();
		int unsigned dz_set[5]     = '{0, 100, 127, 0, 101};
		int unsigned margin_set[5] = '{0, 255, 0, 255, 1};
		for (int i = 0; i < 5; i++) begin
			set_registers(dz_set[i], margin_set[i]);
			send_sample(make_item(ACT_CAPTURE));
			repeat (29) send_sample(make_item(2'($urandom_range(0, 3))));
		end
	endtask

	// capture, a few widening samples, then reads with some stray actions
	task automatic run_calibration_session(input int reads);
		int r;
		logic [1:0] act;
		send_sample(pack_item(ACT_CAPTURE, pick_sample(8'd128), pick_sample(8'd128)));
		repeat ($urandom_range(2, 6)) send_sample(make_item(ACT_CALIBRATE));
		repeat (reads) begin
			r = $urandom_range(0, 19);
			if (r < 1)
				act = ACT_CAPTURE;
			else if (r < 3)
				act = ACT_CALIBRATE;
			else if (r < 4)
				act = ACT_SPARE;
			else
				act = ACT_READ;
			send_sample(make_item(act));
		end
	endtask

	task automatic test_random_sessions();
		int unsigned dz, margin;
		for (int s = 0; s < 9; s++) begin
			if (s != 0) begin
				dz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
					: $urandom_range(0, 25);
				margin = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, 40);
				set_registers(dz, margin);
			end
			idle_on = ($urandom_range(0, 3) != 0);
			run_calibration_session(45);
		end
		idle_on = 1'b1;
	endtask

	// result side held off long enough for the block to fill and stall its input
	task automatic test_backpressure();
		hold_left = HOLD_OFF_CYCLES;
		repeat (25) send_sample(make_item(2'($urandom_range(0, 3))));
	endtask

	task automatic test_streaming();
		idle_on = 1'b0;
		set_registers(10, 10);
		run_calibration_session(70);
	endtask

	initial begin
		cal_x_neutral = '0;
		cal_y_neutral = '0;
		cal_x_max     = '0;
		cal_x_min     = 8'hFF;
		cal_y_max     = '0;
		cal_y_min     = 8'hFF;
		cfg_dead_zone = DEAD_ZONE_RST;
		cfg_margin    = MARGIN_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_register_extremes();
		test_random_sessions();
		test_backpressure();
		test_streaming();

		drain_results();
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
